// ----- rtl/panel_spi_command_serializer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the panel SPI command serializer
// Shared implication checks on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef PANEL_SPI_COMMAND_SERIALIZER_TOP_ASSERT_SVH
`define PANEL_SPI_COMMAND_SERIALIZER_TOP_ASSERT_SVH

// Same-cycle implication
`define PSCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pscs assertion failed");

// Next-cycle implication
`define PSCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pscs assertion failed");

`endif

// ----- rtl/pscs_pkg.sv -----
// ----------------------------------------------------------------------------
// pscs_pkg
// Types, codes and the step decoder of the panel SPI command serializer.
// ----------------------------------------------------------------------------
package pscs_pkg;

  typedef enum logic [1:0] {
    ACT_CMD   = 2'd0,
    ACT_PARAM = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_REGW  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    U_REL  = 2'd0,
    U_BYTE = 2'd1,
    U_ERR  = 2'd2
  } unit_kind_t;

  localparam logic [7:0]  PFX_ADDR_HI   = 8'h20;
  localparam logic [7:0]  PFX_ADDR_LO   = 8'h00;
  localparam logic [7:0]  PFX_DATA      = 8'h40;
  localparam logic [15:0] ADDR_SLP_OUT  = 16'h1100;
  localparam logic [15:0] ADDR_DISP_ON  = 16'h2900;
  localparam logic [7:0]  DATA_SHORT    = 8'hFF;
  localparam logic [3:0]  NINE_LAST_BIT = 4'd8;
  localparam logic [3:0]  EIGHT_LAST_BIT = 4'd7;

  // One accepted request with the frame state seen at acceptance
  typedef struct packed {
    action_t     action;
    logic [7:0]  byte_value;
    logic [15:0] register_address;
    logic        open_before;
  } item_t;

  // One step of a request: a release, a byte, or the error clock
  typedef struct packed {
    unit_kind_t kind;
    logic       dc;
    logic [7:0] value;
    logic       last;
  } unit_t;

  // Decode step idx of a request into a release, byte or error step
  function automatic unit_t get_unit(item_t it, logic [3:0] idx);
    unit_t      u;
    logic       rel_first;
    logic       short_w;
    logic [3:0] j;
    u.kind  = U_REL;
    u.dc    = 1'b0;
    u.value = 8'h00;
    u.last  = 1'b1;
    rel_first = it.open_before && (it.action == ACT_CMD || it.action == ACT_REGW);
    short_w = (it.register_address == ADDR_SLP_OUT || it.register_address == ADDR_DISP_ON)
              && it.byte_value == DATA_SHORT;
    j = rel_first ? idx - 4'd1 : idx;
    if (rel_first && idx == 4'd0) begin
      u.last = 1'b0;
    end else begin
      case (it.action)
        ACT_CMD: begin
          u.kind  = U_BYTE;
          u.value = it.byte_value;
        end
        ACT_PARAM: begin
          if (it.open_before) begin
            u.kind  = U_BYTE;
            u.dc    = 1'b1;
            u.value = it.byte_value;
          end else begin
            u.kind = U_ERR;
          end
        end
        ACT_CLOSE: begin
          u.kind = U_REL;
        end
        default: begin
          u.last = 1'b0;
          case (j)
            4'd0: begin
              u.kind  = U_BYTE;
              u.value = PFX_ADDR_HI;
            end
            4'd1: begin
              u.kind  = U_BYTE;
              u.dc    = 1'b1;
              u.value = it.register_address[15:8];
            end
            4'd3: begin
              u.kind  = U_BYTE;
              u.value = PFX_ADDR_LO;
            end
            4'd4: begin
              u.kind  = U_BYTE;
              u.dc    = 1'b1;
              u.value = it.register_address[7:0];
            end
            4'd5: begin
              u.last = short_w;
            end
            4'd6: begin
              u.kind  = U_BYTE;
              u.value = PFX_DATA;
            end
            4'd7: begin
              u.kind  = U_BYTE;
              u.dc    = 1'b1;
              u.value = it.byte_value;
            end
            4'd2: begin
              u.last = 1'b0;
            end
            default: begin
              u.last = 1'b1;
            end
          endcase
        end
      endcase
    end
    return u;
  endfunction

endpackage

// ----- rtl/pscs_intake.sv -----
// ----------------------------------------------------------------------------
// pscs_intake
// Input request register; tracks whether a frame is open at each request.
// ----------------------------------------------------------------------------
module pscs_intake (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [7:0]          byte_value,
  input  logic [15:0]         register_address,
  output logic                item_valid,
  input  logic                item_take,
  output pscs_pkg::item_t     item
);

  logic slot_valid;
  logic frame_open;
  logic accept;

  assign in_ready   = !slot_valid || item_take;
  assign accept     = in_valid && in_ready;
  assign item_valid = slot_valid;

  // Hold the slot until the emitter takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (accept) begin
      slot_valid <= 1'b1;
    end else if (item_take) begin
      slot_valid <= 1'b0;
    end
  end

  // Capture payload and the frame state seen by this request
  always_ff @(posedge clk) begin
    if (accept) begin
      item.action           <= pscs_pkg::action_t'(action);
      item.byte_value       <= byte_value;
      item.register_address <= register_address;
      item.open_before      <= frame_open;
    end
  end

  // Advance the frame state in request order
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
    end else if (accept) begin
      case (pscs_pkg::action_t'(action))
        pscs_pkg::ACT_CMD:   frame_open <= 1'b1;
        pscs_pkg::ACT_PARAM: frame_open <= frame_open;
        default:             frame_open <= 1'b0;
      endcase
    end
  end

endmodule

// ----- rtl/pscs_emitter.sv -----
// ----------------------------------------------------------------------------
// pscs_emitter
// Walks the steps of one request and registers one serial clock per cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
module pscs_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            nine_bit_mode,
  input  logic            item_valid,
  output logic            item_take,
  input  pscs_pkg::item_t item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            mosi_bit,
  output logic            select_active,
  output logic            error_flag,
  output logic            last
);

  `include "panel_spi_command_serializer_top_assert.svh"

  pscs_pkg::item_t cur;
  logic            cur_valid;
  logic [3:0]      unit_idx;
  logic [3:0]      bit_idx;

  pscs_pkg::unit_t u;
  logic            step;
  logic            byte_end;
  logic            unit_end;
  logic            res_last;
  logic            res_bit;
  logic [3:0]      pos;

  // Decode current step and pick the bit
  always_comb begin
    u        = pscs_pkg::get_unit(cur, unit_idx);
    byte_end = nine_bit_mode ? (bit_idx == pscs_pkg::NINE_LAST_BIT)
                             : (bit_idx == pscs_pkg::EIGHT_LAST_BIT);
    pos      = nine_bit_mode ? (pscs_pkg::NINE_LAST_BIT - bit_idx)
                             : (pscs_pkg::EIGHT_LAST_BIT - bit_idx);
    unit_end = (u.kind != pscs_pkg::U_BYTE) || byte_end;
    res_last = u.last && unit_end;
    if (u.kind != pscs_pkg::U_BYTE) begin
      res_bit = 1'b0;
    end else if (nine_bit_mode && bit_idx == 4'd0) begin
      res_bit = u.dc;
    end else begin
      res_bit = u.value[pos[2:0]];
    end
  end

  assign step      = cur_valid && (!out_valid || out_ready);
  assign item_take = item_valid && (!cur_valid || (step && res_last));

  // Load the next request or advance through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      unit_idx  <= 4'd0;
      bit_idx   <= 4'd0;
    end else if (item_take) begin
      cur_valid <= 1'b1;
      unit_idx  <= 4'd0;
      bit_idx   <= 4'd0;
    end else if (step) begin
      if (res_last) begin
        cur_valid <= 1'b0;
        unit_idx  <= 4'd0;
        bit_idx   <= 4'd0;
      end else if (unit_end) begin
        unit_idx <= unit_idx + 4'd1;
        bit_idx  <= 4'd0;
      end else begin
        bit_idx <= bit_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      cur <= item;
    end
  end

  // Output register: drop when taken, refill on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mosi_bit      <= res_bit;
      select_active <= (u.kind == pscs_pkg::U_BYTE);
      error_flag    <= (u.kind == pscs_pkg::U_ERR);
      last          <= res_last;
    end
  end

  `PSCS_ASSERT_NEXT(a_more_steps, step && !res_last, cur_valid)
  `PSCS_ASSERT_NOW(a_idx_range, cur_valid, unit_idx <= 4'd9 && bit_idx <= 4'd8)
  `PSCS_ASSERT_NOW(a_err_quiet, out_valid && error_flag, !select_active && !mosi_bit && last)
  `PSCS_ASSERT_NOW(a_rel_low, out_valid && !select_active, !mosi_bit)

endmodule

// ----- rtl/panel_spi_command_serializer_top.sv -----
// A request's first serial clock passes the intake slot, the emitter and its output register.
// Throughput: one serial clock per cycle unless out_ready stalls the output; a request
//   makes 1 to 58 serial clocks (8 or 9 per byte), set by the step sequencer in pscs_emitter.
// A new request is taken while the previous one is still being serialized.
// Reset (rst, synchronous): no frame open, nine-bit mode off, no request in flight.
// ----------------------------------------------------------------------------
// panel_spi_command_serializer_top
// Three-wire SPI panel command serializer: request intake, step emitter, config.
// ----------------------------------------------------------------------------
module panel_spi_command_serializer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  byte_value,
  input  logic [15:0] register_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        mosi_bit,
  output logic        select_active,
  output logic        error_flag,
  output logic        last
);

  logic            nine_bit_mode;
  logic            item_valid;
  logic            item_take;
  pscs_pkg::item_t item;

  // Hold the nine-bit mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      nine_bit_mode <= 1'b0;
    end else if (cfg_we) begin
      nine_bit_mode <= cfg_wdata;
    end
  end

  pscs_intake u_intake (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .byte_value       (byte_value),
    .register_address (register_address),
    .item_valid       (item_valid),
    .item_take        (item_take),
    .item             (item)
  );

  pscs_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .nine_bit_mode (nine_bit_mode),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .item          (item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mosi_bit      (mosi_bit),
    .select_active (select_active),
    .error_flag    (error_flag),
    .last          (last)
  );

endmodule

// ----- dv/tb_panel_spi_command_serializer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_panel_spi_command_serializer_top
// Drives command, parameter, close and register-write requests into the panel
// SPI serializer in both eight-bit and nine-bit modes. Each accepted request is
// expanded locally into the serial clocks it should produce, and every output
// clock is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module tb_panel_spi_command_serializer_top;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  // One serial clock on the panel bus
  typedef struct packed {
    logic mosi;
    logic sel;
    logic err;
    logic last;
  } serial_clock_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [7:0]  byte_value;
  logic [15:0] register_address;
  logic        out_valid;
  logic        out_ready;
  logic        mosi_bit;
  logic        select_active;
  logic        error_flag;
  logic        last;

  // Local copy of the block's state and configuration
  logic          nine_bit_on;
  logic          panel_frame_open;
  serial_clock_t serial_clocks_due[$];

  int sender_idle_pct;
  int receiver_idle_pct;
  int requests_sent;
  int clocks_checked;
  int mismatches;
  int error_clocks_seen;
  int release_clocks_seen;
  int stall_cycles;

  panel_spi_command_serializer_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .byte_value       (byte_value),
    .register_address (register_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mosi_bit         (mosi_bit),
    .select_active    (select_active),
    .error_flag       (error_flag),
    .last             (last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void push_clock(logic mosi, logic sel, logic err);
    serial_clock_t c;
    c.mosi = mosi;
    c.sel  = sel;
    c.err  = err;
    c.last = 1'b0;
    serial_clocks_due.push_back(c);
  endfunction

  // Optional data/command bit, then the byte MSB first
  function automatic void push_byte(logic [7:0] value, logic dc);
    if (nine_bit_on) begin
      push_clock(dc, 1'b1, 1'b0);
    end
    for (int i = 7; i >= 0; i--) begin
      push_clock(value[i], 1'b1, 1'b0);
    end
  endfunction

  function automatic void push_frame(logic [7:0] cmd, logic [7:0] param);
    push_byte(cmd, 1'b0);
    push_byte(param, 1'b1);
    push_clock(1'b0, 1'b0, 1'b0);
  endfunction

  // Expand one accepted request into the serial clocks it must produce
  function automatic void predict_serial_clocks(pscs_pkg::action_t act, logic [7:0] val,
                                                logic [15:0] addr);
    int  first_idx;
    bit  short_write;
    first_idx = serial_clocks_due.size();
    short_write = (addr == pscs_pkg::ADDR_SLP_OUT || addr == pscs_pkg::ADDR_DISP_ON)
                  && val == pscs_pkg::DATA_SHORT;
    case (act)
      pscs_pkg::ACT_CMD: begin
        if (panel_frame_open) begin
          push_clock(1'b0, 1'b0, 1'b0);
        end
        push_byte(val, 1'b0);
        panel_frame_open = 1'b1;
      end
      pscs_pkg::ACT_PARAM: begin
        if (panel_frame_open) begin
          push_byte(val, 1'b1);
        end else begin
          push_clock(1'b0, 1'b0, 1'b1);
        end
      end
      pscs_pkg::ACT_CLOSE: begin
        push_clock(1'b0, 1'b0, 1'b0);
        panel_frame_open = 1'b0;
      end
      default: begin
        if (panel_frame_open) begin
          push_clock(1'b0, 1'b0, 1'b0);
        end
        push_frame(pscs_pkg::PFX_ADDR_HI, addr[15:8]);
        push_frame(pscs_pkg::PFX_ADDR_LO, addr[7:0]);
        if (!short_write) begin
          push_frame(pscs_pkg::PFX_DATA, val);
        end
        panel_frame_open = 1'b0;
      end
    endcase
    if (serial_clocks_due.size() > first_idx) begin
      serial_clocks_due[serial_clocks_due.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Present one request, hold it until taken, then predict its clocks
  task automatic send_request(pscs_pkg::action_t act, logic [7:0] val, logic [15:0] addr);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    action           <= act;
    byte_value       <= val;
    register_address <= addr;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_serial_clocks(act, val, addr);
    requests_sent++;
  endtask

  // Drop valid and wait until every due clock has come out
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (serial_clocks_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write the mode register while the block is idle
  task automatic set_panel_mode(logic mode);
    drain_requests();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    nine_bit_on = mode;
  endtask

  // Output side: stall at random on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    serial_clock_t want;
    if (!rst && out_valid && out_ready) begin
      if (serial_clocks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected serial clock: mosi=%b sel=%b err=%b last=%b",
                   $time, mosi_bit, select_active, error_flag, last);
        end
      end else begin
        want = serial_clocks_due.pop_front();
        clocks_checked++;
        if (want.err) error_clocks_seen++;
        if (!want.sel && !want.err) release_clocks_seen++;
        if (mosi_bit !== want.mosi || select_active !== want.sel ||
            error_flag !== want.err || last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] clock %0d mismatch: exp mosi=%b sel=%b err=%b last=%b",
                     $time, clocks_checked, want.mosi, want.sel, want.err, want.last);
            $display("             got mosi=%b sel=%b err=%b last=%b",
                     mosi_bit, select_active, error_flag, last);
          end
        end
      end
    end
  end

  // Stop a hung run: count cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d idle cycles, %0d clocks still due",
                 stall_cycles, serial_clocks_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Corner requests: field extremes, release before command, error, short writes
  task automatic test_directed_requests(logic mode);
    set_panel_mode(mode);
    send_request(pscs_pkg::ACT_CMD,   8'h00, 16'h0000);
    send_request(pscs_pkg::ACT_PARAM, 8'hFF, 16'hFFFF);
    send_request(pscs_pkg::ACT_PARAM, 8'h00, 16'h0000);
    send_request(pscs_pkg::ACT_CMD,   8'hA5, 16'h0000);
    send_request(pscs_pkg::ACT_CLOSE, 8'hFF, 16'hFFFF);
    send_request(pscs_pkg::ACT_CLOSE, 8'h00, 16'h0000);
    send_request(pscs_pkg::ACT_PARAM, 8'h5A, 16'h0000);
    send_request(pscs_pkg::ACT_REGW,  8'h00, 16'hFFFF);
    send_request(pscs_pkg::ACT_CMD,   8'hFF, 16'h0000);
    send_request(pscs_pkg::ACT_REGW,  8'hFF, 16'h0000);
    send_request(pscs_pkg::ACT_REGW,  8'hFF, pscs_pkg::ADDR_SLP_OUT);
    send_request(pscs_pkg::ACT_CMD,   8'h11, 16'h0000);
    send_request(pscs_pkg::ACT_REGW,  8'hFF, pscs_pkg::ADDR_DISP_ON);
    send_request(pscs_pkg::ACT_REGW,  8'hFE, pscs_pkg::ADDR_SLP_OUT);
    send_request(pscs_pkg::ACT_REGW,  8'hFF, 16'h2901);
  endtask

  // Mostly well-formed frames with random content, some writes, some noise
  task automatic test_random_traffic(int n_requests, logic mode);
    int start;
    int pick;
    int n_params;
    logic [7:0]  val;
    logic [15:0] addr;
    set_panel_mode(mode);
    start = requests_sent;
    while (requests_sent - start < n_requests) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_request(pscs_pkg::ACT_CMD, 8'($urandom), 16'($urandom));
        n_params = $urandom_range(0, 4);
        repeat (n_params) send_request(pscs_pkg::ACT_PARAM, 8'($urandom), 16'($urandom));
        // leave some frames open so the next command must release first
        if ($urandom_range(0, 99) < 80) begin
          send_request(pscs_pkg::ACT_CLOSE, 8'($urandom), 16'($urandom));
        end
      end else if (pick < 85) begin
        addr = 16'($urandom);
        val  = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          addr = $urandom_range(0, 1) ? pscs_pkg::ADDR_SLP_OUT : pscs_pkg::ADDR_DISP_ON;
        end
        if ($urandom_range(0, 3) == 0) val = pscs_pkg::DATA_SHORT;
        send_request(pscs_pkg::ACT_REGW, val, addr);
      end else begin
        send_request(pscs_pkg::action_t'($urandom_range(0, 3)),
                     8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_valid         = 1'b0;
    action           = pscs_pkg::ACT_CMD;
    byte_value       = 8'h00;
    register_address = 16'h0000;
    out_ready        = 1'b0;
    nine_bit_on      = 1'b0;
    panel_frame_open = 1'b0;
    sender_idle_pct   = 30;
    receiver_idle_pct = 83;
    requests_sent       = 0;
    clocks_checked      = 0;
    mismatches          = 0;
    error_clocks_seen   = 0;
    release_clocks_seen = 0;
    stall_cycles        = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_requests(1'b0);
    test_directed_requests(1'b1);
    test_random_traffic(120, 1'b1);
    sender_idle_pct   = 83;
    receiver_idle_pct = 30;
    test_random_traffic(120, 1'b0);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_traffic(60, 1'b1);
    test_random_traffic(60, 1'b0);

    drain_requests();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests in eight- and nine-bit modes, %0d serial clocks checked",
             requests_sent, clocks_checked);
    $display("(%0d select releases, %0d orphan-parameter errors), %0d mismatches",
             release_clocks_seen, error_clocks_seen, mismatches);
    if (mismatches == 0 && serial_clocks_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- panel_spi_command_serializer_top.f -----
+incdir+rtl
rtl/pscs_pkg.sv
rtl/pscs_intake.sv
rtl/pscs_emitter.sv
rtl/panel_spi_command_serializer_top.sv
dv/tb_panel_spi_command_serializer_top.sv
